// File: src/oawt_pkg.sv
`default_nettype none
package oawt_pkg;
   localparam int TableDepth = 4096;
   localparam int MaxWord    = 16;
   localparam int SlotW      = $clog2(TableDepth);
   localparam int PrimeW     = 13;
   localparam int LenW       = $clog2(MaxWord + 1) + 1;
   localparam int PosW       = $clog2(MaxWord);
   localparam int HashW      = 32;
   localparam int SeedW      = 32;
   localparam int CsrIdxW    = 1;

   localparam logic [CsrIdxW-1:0] RegPrime = 1'd0;
   localparam logic [CsrIdxW-1:0] RegSeed  = 1'd1;

   typedef enum logic [2:0] {
      StInserted = 3'd0,
      StFound    = 3'd1,
      StNotFound = 3'd2,
      StFull     = 3'd3,
      StTooLong  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_RED, S_HOME, S_PROBE, S_RDWAIT, S_CHECK, S_CMP, S_COPY, S_DONE
   } state_type;
endpackage
`default_nettype wire

// File: src/oawt_if.sv
`default_nettype none
interface oawt_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [7:0] char_code;
   logic last_char;
   modport source (output valid, op, char_code, last_char, input ready);
   modport sink   (input valid, op, char_code, last_char, output ready);
endinterface

interface oawt_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic [11:0] slot;
   logic [12:0] touches;
   modport source (output valid, status, slot, touches, input ready);
   modport sink   (input valid, status, slot, touches, output ready);
endinterface
`default_nettype wire

// File: src/oawt_reducer.sv
`default_nettype none
// Sequential modular reduction: value mod prime by restoring subtraction of
// shifted copies of the prime, one shift position per cycle.
module oawt_reducer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [38:0] value,
   input  wire logic [oawt_pkg::PrimeW-1:0] prime,
   output logic             done,
   output logic [oawt_pkg::PrimeW-1:0] result
);
   localparam int ValW  = 39;
   localparam int ShW   = ValW - 2;
   logic [ValW-1:0] rem_ff, rem_in;
   logic [ValW-1:0] rem_step;
   logic [5:0]      sh_ff, sh_in;
   logic            busy_ff, busy_in;
   logic [ValW+ShW-1:0] trial;

   // Subtract prime << sh when it fits.
   always_comb begin
      trial    = {{(ValW+ShW-oawt_pkg::PrimeW){1'b0}}, prime} << sh_ff;
      rem_step = ({{ShW{1'b0}}, rem_ff} >= trial) ? rem_ff - trial[ValW-1:0] : rem_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      busy_in  = busy_ff;
      if (start) begin
         rem_in  = value;
         sh_in   = 6'(ShW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_step;
         if (sh_ff == 6'd0) busy_in = 1'b0;
         else sh_in = sh_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   // The last shift position gives the final remainder.
   assign done   = busy_ff && (sh_ff == 6'd0);
   assign result = rem_step[oawt_pkg::PrimeW-1:0];
endmodule
`default_nettype wire

// File: src/open_address_word_table_unit.sv
`default_nettype none
// One transaction at a time. A character without the end flag goes from acceptance
// through a setup state and a bit-serial reduction of key*33+char by the prime. The
// last character of a word that is not too long adds a reduction for the home slot,
// then probe, read-wait and check states per probed slot, a copy state per
// character written or compare states one more than the characters compared, and
// a posting state. Synchronous reset clears all 4096 slots while holding off input.
module open_address_word_table_unit (
   input  wire logic clock,
   input  wire logic reset,
   oawt_req_if.sink  req,
   oawt_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic [oawt_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int SW = oawt_pkg::SlotW;
   localparam int PW = oawt_pkg::PrimeW;
   localparam int LW = oawt_pkg::LenW;
   localparam int QW = oawt_pkg::PosW;

   // Memories.
   logic                used_mem  [oawt_pkg::TableDepth];
   logic [7:0]          chars_mem [oawt_pkg::TableDepth*oawt_pkg::MaxWord];
   logic [LW-1:0]       len_mem   [oawt_pkg::TableDepth];
   logic [7:0]          wbuf_ff   [oawt_pkg::MaxWord];

   oawt_pkg::state_type state_ff, state_in;
   logic [PW-1:0]  prime_ff;
   logic [31:0]    seed_ff;
   logic [31:0]    hash_ff, hash_in;
   logic [LW-1:0]  wlen_ff, wlen_in;
   logic           op_ff, last_ff;
   logic [7:0]     ch_ff;
   logic [SW:0]    clr_ff;
   logic           clearing;
   logic [PW-1:0]  eprime;
   logic [PW-1:0]  dist_ff, dist_in;
   logic [PW-1:0]  slot_ff, slot_in;
   logic [QW:0]    pos_ff, pos_in;
   logic           rd_used_ff;
   logic [LW-1:0]  rd_len_ff;
   logic [7:0]     rd_ch_ff;
   logic           rsp_valid_ff;
   oawt_pkg::status_type st_ff, st_in;
   logic [11:0]    rslot_ff, rslot_in;
   logic [12:0]    rtch_ff, rtch_in;
   oawt_pkg::status_type rsp_st_ff;
   logic [11:0]    rsp_slot_ff;
   logic [12:0]    rsp_tch_ff;
   logic           red_start, red_done;
   logic [38:0]    red_val;
   logic [PW-1:0]  red_res;
   logic           acc, fin;
   logic [SW-1:0]  sidx;

   assign clearing = !clr_ff[SW];
   assign eprime = (prime_ff < PW'(2)) ? PW'(2) :
                   (prime_ff > PW'(oawt_pkg::TableDepth)) ? PW'(oawt_pkg::TableDepth)
                   : prime_ff;
   assign req.ready = (state_ff == oawt_pkg::S_IDLE) && !clearing;
   assign acc  = req.valid && req.ready;
   assign sidx = slot_ff[SW-1:0];

   // Shared reducer for the per-character hash and the home slot.
   assign red_val = (state_ff == oawt_pkg::S_RED) ? {26'd0, red_res} :
                    ({7'd0, (wlen_ff == '0) ? seed_ff : hash_ff} * 39'd33) + {31'd0, ch_ff};
   oawt_reducer u_red (.clock, .reset, .start(red_start), .value(red_val),
                       .prime(eprime), .done(red_done), .result(red_res));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         oawt_pkg::S_IDLE:   if (acc) state_in = oawt_pkg::S_MUL;
         oawt_pkg::S_MUL:    state_in = oawt_pkg::S_RED;
         oawt_pkg::S_RED:    if (red_done) state_in = !last_ff ? oawt_pkg::S_IDLE :
                                 (wlen_ff >= LW'(oawt_pkg::MaxWord)) ? oawt_pkg::S_DONE :
                                 oawt_pkg::S_HOME;
         oawt_pkg::S_HOME:   if (red_done) state_in = oawt_pkg::S_PROBE;
         oawt_pkg::S_PROBE:  state_in = (dist_ff == eprime) ? oawt_pkg::S_DONE
                                        : oawt_pkg::S_RDWAIT;
         oawt_pkg::S_RDWAIT: state_in = oawt_pkg::S_CHECK;
         oawt_pkg::S_CHECK:  begin
            if (!op_ff) state_in = rd_used_ff ? oawt_pkg::S_PROBE : oawt_pkg::S_COPY;
            else if (rd_used_ff && rd_len_ff == wlen_ff) state_in = oawt_pkg::S_CMP;
            else state_in = oawt_pkg::S_PROBE;
         end
         oawt_pkg::S_CMP:    begin
            if (rd_ch_ff != wbuf_ff[pos_ff[QW-1:0] - QW'(1)] && pos_ff != '0)
               state_in = oawt_pkg::S_PROBE;
            else if (LW'(pos_ff) == wlen_ff) state_in = oawt_pkg::S_DONE;
         end
         oawt_pkg::S_COPY:   if (LW'(pos_ff) + LW'(1) >= wlen_ff) state_in = oawt_pkg::S_DONE;
         oawt_pkg::S_DONE:   if (!rsp_valid_ff || rsp.ready) state_in = oawt_pkg::S_IDLE;
         default:            state_in = oawt_pkg::S_IDLE;
      endcase
   end

   // Datapath controls.
   always_comb begin
      red_start = 1'b0;
      hash_in = hash_ff; wlen_in = wlen_ff;
      dist_in = dist_ff; slot_in = slot_ff; pos_in = pos_ff;
      st_in = st_ff; rslot_in = rslot_ff; rtch_in = rtch_ff;
      fin = 1'b0;
      unique case (state_ff)
         oawt_pkg::S_MUL: red_start = 1'b1;
         oawt_pkg::S_RED: if (red_done) begin
            hash_in = {19'd0, red_res};
            if (wlen_ff <= LW'(oawt_pkg::MaxWord)) wlen_in = wlen_ff + LW'(1);
            st_in = oawt_pkg::StTooLong; rslot_in = '0; rtch_in = '0;
            red_start = last_ff && !(wlen_ff + LW'(1) > LW'(oawt_pkg::MaxWord)
                                     && wlen_ff >= LW'(oawt_pkg::MaxWord));
         end
         oawt_pkg::S_HOME: if (red_done) begin
            slot_in = red_res; dist_in = '0;
            st_in = op_ff ? oawt_pkg::StNotFound : oawt_pkg::StFull;
         end
         oawt_pkg::S_PROBE: pos_in = '0;
         oawt_pkg::S_CHECK: if (!(!op_ff && !rd_used_ff) &&
                                !(op_ff && rd_used_ff && rd_len_ff == wlen_ff)) begin
            dist_in = dist_ff + PW'(1);
            slot_in = (slot_ff + PW'(1) == eprime) ? '0 : slot_ff + PW'(1);
         end
         oawt_pkg::S_CMP: begin
            if (rd_ch_ff != wbuf_ff[pos_ff[QW-1:0] - QW'(1)] && pos_ff != '0) begin
               dist_in = dist_ff + PW'(1);
               slot_in = (slot_ff + PW'(1) == eprime) ? '0 : slot_ff + PW'(1);
            end else if (LW'(pos_ff) == wlen_ff) begin
               st_in = oawt_pkg::StFound; rslot_in = sidx;
               rtch_in = (dist_ff == '0) ? 13'd1 : dist_ff;
            end else pos_in = pos_ff + 1'b1;
         end
         oawt_pkg::S_COPY: begin
            pos_in = pos_ff + 1'b1;
            st_in = oawt_pkg::StInserted; rslot_in = sidx; rtch_in = '0;
         end
         oawt_pkg::S_DONE: begin
            // The result is posted once the output register is free.
            fin = !rsp_valid_ff || rsp.ready;
            if (fin) begin
               wlen_in = '0; hash_in = seed_ff;
            end
         end
         default: ;
      endcase
      if (csr_we && csr_index == oawt_pkg::RegSeed && wlen_in == '0 && !fin)
         hash_in = csr_wdata;
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oawt_pkg::S_IDLE;
         prime_ff <= PW'(4093);
         seed_ff <= 32'd5381;
         hash_ff <= 32'd5381;
         wlen_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= fin && csr_we && csr_index == oawt_pkg::RegSeed ? csr_wdata : hash_in;
         wlen_ff <= wlen_in;
         if (clearing) clr_ff <= clr_ff + 1'b1;
         if (csr_we && csr_index == oawt_pkg::RegPrime) prime_ff <= csr_wdata[PW-1:0];
         if (csr_we && csr_index == oawt_pkg::RegSeed) seed_ff <= csr_wdata;
         if (fin) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (acc) begin
         op_ff <= req.op; ch_ff <= req.char_code; last_ff <= req.last_char;
      end
      if (state_ff == oawt_pkg::S_RED && red_done && wlen_ff < LW'(oawt_pkg::MaxWord))
         wbuf_ff[wlen_ff[QW-1:0]] <= ch_ff;
      dist_ff <= dist_in; slot_ff <= slot_in; pos_ff <= pos_in;
      st_ff <= st_in; rslot_ff <= rslot_in; rtch_ff <= rtch_in;
      // Output register, so that a waiting result does not hold off the next word.
      if (fin) begin
         rsp_st_ff <= st_ff; rsp_slot_ff <= rslot_ff; rsp_tch_ff <= rtch_ff;
      end
   end

   // Table memories.
   always_ff @(posedge clock) begin
      if (clearing) used_mem[clr_ff[SW-1:0]] <= 1'b0;
      else if (state_ff == oawt_pkg::S_COPY && LW'(pos_ff) + LW'(1) >= wlen_ff)
         used_mem[sidx] <= 1'b1;
      rd_used_ff <= used_mem[sidx];
   end
   always_ff @(posedge clock) begin
      if (state_ff == oawt_pkg::S_COPY) len_mem[sidx] <= wlen_ff;
      rd_len_ff <= len_mem[sidx];
   end
   always_ff @(posedge clock) begin
      if (state_ff == oawt_pkg::S_COPY)
         chars_mem[{sidx, pos_ff[QW-1:0]}] <= wbuf_ff[pos_ff[QW-1:0]];
      rd_ch_ff <= chars_mem[{sidx, pos_ff[QW-1:0]}];
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_st_ff;
   assign rsp.slot    = rsp_slot_ff;
   assign rsp.touches = rsp_tch_ff;

   // Checks.
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req.ready) else $error("accept during clear");
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == oawt_pkg::S_CHECK) |-> (slot_ff < eprime))
      else $error("probe slot out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
endmodule
`default_nettype wire

// File: verif/open_address_word_table_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module open_address_word_table_unit_test;

   // Bounds a run with tables of up to 4096 slots and heavy stalls.
   localparam int CycleLimit = 400_000_000;
   localparam int SettleCycles = 120;

   typedef struct packed {
      oawt_pkg::status_type status;
      logic [11:0] slot;
      logic [12:0] touches;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [oawt_pkg::CsrIdxW-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   oawt_req_if req_if ();
   oawt_rsp_if rsp_if ();

   open_address_word_table_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow of the word table, kept in step with every accepted transaction.
   logic [12:0] tbl_prime;
   logic [31:0] tbl_seed;
   bit          tbl_used [oawt_pkg::TableDepth];
   logic [7:0]  tbl_chars [oawt_pkg::TableDepth][oawt_pkg::MaxWord];
   int          tbl_len [oawt_pkg::TableDepth];
   logic [7:0]  cur_word [oawt_pkg::MaxWord];
   int          cur_len;
   logic [31:0] cur_hash;

   lookup_result_type pending_results[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int results_seen = 0;
   int words_sent = 0;
   int cycles = 0;

   always #4 clock = ~clock;

   // Cycle budget for the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Each accepted result is compared with the oldest expectation.
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen <= results_seen + 1;
         if (pending_results.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
               $display("Unexpected result: status %0d slot %0d touches %0d",
                        rsp_if.status, rsp_if.slot, rsp_if.touches);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status || rsp_if.slot !== want.slot ||
                rsp_if.touches !== want.touches) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("Mismatch: expected status %0d slot %0d touches %0d, %s %0d %0d %0d",
                           want.status, want.slot, want.touches, "got",
                           rsp_if.status, rsp_if.slot, rsp_if.touches);
            end
         end
      end
   end

   function automatic int prime_in_force();
      if (tbl_prime < 2) return 2;
      if (tbl_prime > oawt_pkg::TableDepth) return oawt_pkg::TableDepth;
      return int'(tbl_prime);
   endfunction

   function automatic bit slot_holds_word(int s);
      if (!tbl_used[s] || tbl_len[s] != cur_len) return 0;
      for (int i = 0; i < cur_len; i++)
         if (tbl_chars[s][i] !== cur_word[i]) return 0;
      return 1;
   endfunction

   // Hash one character into the word; on the last one, insert or look up.
   task automatic absorb_char(bit op, logic [7:0] ch, bit last);
      int prime;
      int home;
      int s;
      logic [63:0] base;
      lookup_result_type res;
      prime = prime_in_force();
      base = (cur_len == 0) ? {32'b0, tbl_seed} : {32'b0, cur_hash};
      cur_hash = 32'((base * 33 + ch) % prime);
      if (cur_len < oawt_pkg::MaxWord) cur_word[cur_len] = ch;
      if (cur_len <= oawt_pkg::MaxWord) cur_len++;
      if (!last) return;
      home = int'(cur_hash) % prime;
      res = '{oawt_pkg::StInserted, 12'd0, 13'd0};
      if (cur_len > oawt_pkg::MaxWord) begin
         res.status = oawt_pkg::StTooLong;
      end else if (op == 1'b0) begin
         res.status = oawt_pkg::StFull;
         for (int d = 0; d < prime; d++) begin
            s = (home + d) % prime;
            if (!tbl_used[s]) begin
               for (int i = 0; i < cur_len; i++) tbl_chars[s][i] = cur_word[i];
               tbl_len[s] = cur_len;
               tbl_used[s] = 1;
               res.status = oawt_pkg::StInserted;
               res.slot = 12'(s);
               break;
            end
         end
      end else begin
         res.status = oawt_pkg::StNotFound;
         for (int d = 0; d < prime; d++) begin
            s = (home + d) % prime;
            if (slot_holds_word(s)) begin
               res.status = oawt_pkg::StFound;
               res.slot = 12'(s);
               res.touches = (d == 0) ? 13'd1 : 13'(d);
               break;
            end
         end
      end
      cur_len = 0;
      cur_hash = tbl_seed;
      pending_results.push_back(res);
   endtask

   // Send one character as a transaction; the sender idles at random first.
   task automatic send_char(bit op, logic [7:0] ch, bit last);
      int gap;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.char_code <= ch;
      req_if.last_char <= last;
      do @(posedge clock); while (!req_if.ready);
      absorb_char(op, ch, last);
   endtask

   // Earlier characters carry a random op; only the last one counts.
   task automatic send_word(bit op, logic [7:0] chars[$]);
      for (int i = 0; i < chars.size(); i++)
         send_char((i == chars.size() - 1) ? op : 1'($urandom), chars[i],
                   i == chars.size() - 1);
      words_sent++;
   endtask

   // Wait until every result is in and the block has settled.
   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(logic [oawt_pkg::CsrIdxW-1:0] idx, logic [31:0] data);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == oawt_pkg::RegPrime) begin
         tbl_prime = data[12:0];
      end else begin
         tbl_seed = data;
         if (cur_len == 0) cur_hash = tbl_seed;
      end
   endtask

   // Plain inserts and lookups under the reset settings, with extreme codes.
   task automatic test_reset_settings();
      send_word(1'b0, '{8'h61});
      send_word(1'b1, '{8'h61});
      send_word(1'b0, '{8'h61});
      send_word(1'b0, '{8'h00, 8'hFF, 8'h01});
      send_word(1'b1, '{8'h00, 8'hFF, 8'h01});
      send_word(1'b1, '{8'h62});
   endtask

   // Collisions, a full table and an overlong word under a tiny modulus.
   task automatic test_small_table();
      write_reg(oawt_pkg::RegPrime, 32'd3);
      write_reg(oawt_pkg::RegSeed, 32'd0);
      send_word(1'b0, '{8'h41});
      send_word(1'b0, '{8'h41});
      send_word(1'b0, '{8'h42});
      send_word(1'b1, '{8'h42});
      send_word(1'b0, '{8'h43});
      send_word(1'b1, '{8'h44});
      send_word(1'b0, '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
                        8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71});
   endtask

   // Out-of-range moduli, extreme seeds and register changes inside a word.
   task automatic test_register_edges();
      write_reg(oawt_pkg::RegPrime, 32'd0);
      write_reg(oawt_pkg::RegSeed, 32'hFFFF_FFFF);
      send_word(1'b0, '{8'h7A});
      write_reg(oawt_pkg::RegPrime, 32'd1);
      send_word(1'b1, '{8'h7A});
      write_reg(oawt_pkg::RegPrime, 32'h1FFF);
      send_word(1'b0, '{8'h80, 8'h7F});
      send_char(1'b0, 8'h55, 1'b0);
      write_reg(oawt_pkg::RegPrime, 32'd7);
      write_reg(oawt_pkg::RegSeed, 32'd12345);
      send_char(1'b0, 8'hAA, 1'b1);
      send_char(1'b1, 8'h55, 1'b0);
      write_reg(oawt_pkg::RegPrime, 32'd4096);
      send_char(1'b1, 8'hAA, 1'b1);
   endtask

   // Random words, mostly short ones from a small alphabet so lookups hit.
   task automatic test_random_words(int char_budget);
      int sent;
      int len;
      int pick;
      logic [7:0] chars[$];
      int primes[10] = '{2, 3, 5, 7, 11, 13, 17, 31, 61, 127};
      sent = 0;
      while (sent < char_budget) begin
         if ($urandom_range(59) == 0) begin
            pick = $urandom_range(19);
            if (pick == 0) write_reg(oawt_pkg::RegPrime, 32'($urandom_range(2000, 4096)));
            else if (pick < 3) write_reg(oawt_pkg::RegSeed, $urandom);
            else write_reg(oawt_pkg::RegPrime, 32'(primes[$urandom_range(9)]));
         end
         chars.delete();
         len = ($urandom_range(19) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 3);
         for (int i = 0; i < len; i++)
            chars.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(97, 99)));
         send_word(($urandom_range(99) < 55) ? 1'b1 : 1'b0, chars);
         sent += len;
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.op = 1'b0;
      req_if.char_code = '0;
      req_if.last_char = 1'b0;
      tbl_prime = 13'd4093;
      tbl_seed = 32'd5381;
      foreach (tbl_used[i]) tbl_used[i] = 0;
      cur_len = 0;
      cur_hash = tbl_seed;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      stall_pct = 63;
      test_small_table();
      idle_pct = 63;
      stall_pct = 0;
      test_register_edges();

      // Random traffic under each idling and stalling mix; drains let the table settle.
      idle_pct = 0;  stall_pct = 0;
      write_reg(oawt_pkg::RegPrime, 32'd11);
      test_random_words(260);
      idle_pct = 63; stall_pct = 0;
      test_random_words(260);
      drain();
      idle_pct = 0;  stall_pct = 63;
      write_reg(oawt_pkg::RegPrime, 32'd2);
      test_random_words(260);
      idle_pct = 28; stall_pct = 28;
      write_reg(oawt_pkg::RegPrime, 32'd31);
      test_random_words(260);

      drain();
      $display("Covered %0d words and %0d results, moduli from 2 to 4096 and beyond,",
               words_sent, results_seen);
      $display("full tables, overlong words and mid-word register changes.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
src/oawt_pkg.sv
src/oawt_if.sv
src/oawt_reducer.sv
src/open_address_word_table_unit.sv
verif/open_address_word_table_unit_test.sv
